// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers for the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DTM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dtm_pkg.sv =====
// ---------------------------------------------------------------------------
// dtm_pkg
// shared types and constants of the distance to measure unit
// ---------------------------------------------------------------------------
`default_nettype none

package dtm_pkg;

  localparam int SAMPLES    = 1024;
  localparam int IDX_W      = 10;
  localparam int VAL_W      = 16;
  localparam int SUM_W      = 48;
  localparam int CSUB_W     = 19;
  localparam int CNT_W      = 6;
  localparam int DIV_STEPS  = 48;
  localparam int SQRT_STEPS = 16;

  localparam logic [VAL_W-1:0] BOUND_RESET = 16'd256;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_NEIGHBOR = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL1 = 7'b0000010,
    ST_MUL2 = 7'b0000100,
    ST_ACC  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_SQRT = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  typedef struct packed {
    logic              ge;
    logic [CSUB_W-1:0] diff;
  } csub_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dtm_csub.sv =====
// ---------------------------------------------------------------------------
// dtm_csub
// shared compare and subtract unit for the divide and root steps
// ---------------------------------------------------------------------------
`default_nettype none

module dtm_csub (
  input  wire logic [dtm_pkg::CSUB_W-1:0] a,
  input  wire logic [dtm_pkg::CSUB_W-1:0] b,
  output dtm_pkg::csub_res_t              res
);

  logic [dtm_pkg::CSUB_W:0] d;

  assign d        = {1'b0, a} - {1'b0, b};
  assign res.ge   = ~d[dtm_pkg::CSUB_W];
  assign res.diff = d[dtm_pkg::CSUB_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/distance_to_measure_unit.sv =====
// ---------------------------------------------------------------------------
// distance_to_measure_unit
// weighted distance to measure: weight store, multiply-accumulate per
// neighbour, then restoring divide and square root per grid point
// ---------------------------------------------------------------------------
//  channel  direction  signals                                        handshake
//  in       input      op, sample_index, value, last_neighbour        valid/stall
//  out      output     dtm_value, bound_not_reached                   valid/stall
//  cfg      input      data (weight_bound)                            valid/ready
//
//  weight load: written to the store as it is taken; neighbour: weight read,
//  two passes of the shared multiplier, accumulate
//  last neighbour: as above, then, for a nonzero bound, 48 divide steps and 16
//  root steps, one bit per cycle from the one compare/subtract unit, then done
//  result sits in an output register; the next item is taken while it waits
//  rst_n is synchronous; the weight store has no reset and needs none
// ---------------------------------------------------------------------------
`default_nettype none

module distance_to_measure_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_op,
  input  wire logic [dtm_pkg::IDX_W-1:0]   in_sample_index,
  input  wire logic [dtm_pkg::VAL_W-1:0]   in_value,
  input  wire logic                        in_last_neighbour,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [dtm_pkg::VAL_W-1:0]        out_dtm_value,
  output logic                             out_bound_not_reached,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [dtm_pkg::VAL_W-1:0]   cfg_data
);

  dtm_pkg::state_t state_r, state_nxt;

  logic [dtm_pkg::VAL_W-1:0]  mem [dtm_pkg::SAMPLES];
  logic [dtm_pkg::VAL_W-1:0]  rd_data_r;

  logic [dtm_pkg::VAL_W-1:0]  bound_r, bound_nxt;
  logic [dtm_pkg::VAL_W-1:0]  val_r, val_nxt;
  logic                       last_r, last_nxt;
  logic [dtm_pkg::VAL_W-1:0]  taken_r, taken_nxt;
  logic [dtm_pkg::VAL_W-1:0]  used_r, used_nxt;
  logic [dtm_pkg::SUM_W-1:0]  prod_r, prod_nxt;
  logic [dtm_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [dtm_pkg::SUM_W-1:0]  div_r, div_nxt;
  logic [16:0]                rem_r, rem_nxt;
  logic [dtm_pkg::VAL_W-1:0]  root_r, root_nxt;
  logic                       flag_r, flag_nxt;
  logic [dtm_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [dtm_pkg::VAL_W-1:0]  out_value_r, out_value_nxt;
  logic                       out_flag_r, out_flag_nxt;

  logic                       in_fire;
  logic                       out_load;
  logic [dtm_pkg::VAL_W-1:0]  remaining;
  logic [dtm_pkg::VAL_W-1:0]  taken_c;
  logic [31:0]                mul_a;
  logic [dtm_pkg::VAL_W-1:0]  mul_b;
  logic [dtm_pkg::SUM_W-1:0]  mul_p;
  logic [dtm_pkg::SUM_W-1:0]  sum_acc;
  logic [dtm_pkg::SUM_W-1:0]  div_step;
  logic [31:0]                quo_sat;
  logic [dtm_pkg::CSUB_W-1:0] csub_a, csub_b;
  dtm_pkg::csub_res_t         csub_res;

  assign in_stall  = (state_r != dtm_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = (state_r == dtm_pkg::ST_IDLE);

  assign out_valid             = out_valid_r;
  assign out_dtm_value         = out_value_r;
  assign out_bound_not_reached = out_flag_r;

  // weight store
  always_ff @(posedge clk) begin
    if (in_fire && in_op == dtm_pkg::OP_LOAD) begin
      mem[in_sample_index] <= in_value;
    end
    if (in_fire && in_op == dtm_pkg::OP_NEIGHBOR) begin
      rd_data_r <= mem[in_sample_index];
    end
  end

  dtm_csub u_csub (
    .a   (csub_a),
    .b   (csub_b),
    .res (csub_res)
  );

  always_comb begin
    case (state_r)
      dtm_pkg::ST_DIV: begin
        csub_a = {2'b00, rem_r[15:0], div_r[dtm_pkg::SUM_W-1]};
        csub_b = {3'b000, bound_r};
      end
      dtm_pkg::ST_SQRT: begin
        csub_a = {rem_r, div_r[31:30]};
        csub_b = {1'b0, root_r, 2'b01};
      end
      default: begin
        csub_a = '0;
        csub_b = '0;
      end
    endcase
  end

  // shared multiplier: square first, then scale by the taken weight
  always_comb begin
    if (state_r == dtm_pkg::ST_MUL2) begin
      mul_a = prod_r[31:0];
      mul_b = taken_r;
    end else begin
      mul_a = {16'h0000, val_r};
      mul_b = val_r;
    end
  end

  assign mul_p     = {16'h0000, mul_a} * {32'h0000_0000, mul_b};
  assign remaining = (bound_r > used_r) ? (bound_r - used_r) : '0;
  assign taken_c   = (rd_data_r < remaining) ? rd_data_r : remaining;
  assign sum_acc   = sum_r + prod_r;
  assign div_step  = {div_r[dtm_pkg::SUM_W-2:0], csub_res.ge};
  assign quo_sat   = (|div_step[dtm_pkg::SUM_W-1:32]) ? 32'hFFFF_FFFF : div_step[31:0];
  assign out_load  = (state_r == dtm_pkg::ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    bound_nxt     = bound_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    taken_nxt     = taken_r;
    used_nxt      = used_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    flag_nxt      = flag_r;
    cnt_nxt       = cnt_r;
    out_value_nxt = out_value_r;
    out_flag_nxt  = out_flag_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cfg_valid && cfg_ready) begin
      bound_nxt = cfg_data;
    end

    case (state_r)
      dtm_pkg::ST_IDLE: begin
        if (in_fire && in_op == dtm_pkg::OP_NEIGHBOR) begin
          val_nxt   = in_value;
          last_nxt  = in_last_neighbour;
          state_nxt = dtm_pkg::ST_MUL1;
        end
      end
      dtm_pkg::ST_MUL1: begin
        prod_nxt  = mul_p;
        taken_nxt = taken_c;
        used_nxt  = used_r + taken_c;
        state_nxt = dtm_pkg::ST_MUL2;
      end
      dtm_pkg::ST_MUL2: begin
        prod_nxt  = mul_p;
        state_nxt = dtm_pkg::ST_ACC;
      end
      dtm_pkg::ST_ACC: begin
        if (!last_r) begin
          sum_nxt   = sum_acc;
          state_nxt = dtm_pkg::ST_IDLE;
        end else begin
          sum_nxt  = '0;
          used_nxt = '0;
          if (bound_r == '0) begin
            root_nxt  = '0;
            flag_nxt  = 1'b0;
            state_nxt = dtm_pkg::ST_DONE;
          end else begin
            flag_nxt  = (used_r < bound_r);
            div_nxt   = sum_acc;
            rem_nxt   = '0;
            cnt_nxt   = dtm_pkg::CNT_W'(dtm_pkg::DIV_STEPS - 1);
            state_nxt = dtm_pkg::ST_DIV;
          end
        end
      end
      dtm_pkg::ST_DIV: begin
        rem_nxt = csub_res.ge ? {1'b0, csub_res.diff[15:0]} : {1'b0, csub_a[15:0]};
        div_nxt = div_step;
        cnt_nxt = cnt_r - dtm_pkg::CNT_W'(1);
        if (cnt_r == '0) begin
          div_nxt   = {16'h0000, quo_sat};
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = dtm_pkg::CNT_W'(dtm_pkg::SQRT_STEPS - 1);
          state_nxt = dtm_pkg::ST_SQRT;
        end
      end
      dtm_pkg::ST_SQRT: begin
        rem_nxt  = csub_res.ge ? csub_res.diff[16:0] : csub_a[16:0];
        root_nxt = {root_r[dtm_pkg::VAL_W-2:0], csub_res.ge};
        div_nxt  = {div_r[dtm_pkg::SUM_W-3:0], 2'b00};
        cnt_nxt  = cnt_r - dtm_pkg::CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = dtm_pkg::ST_DONE;
        end
      end
      dtm_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = root_r;
          out_flag_nxt  = flag_r;
          state_nxt     = dtm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dtm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dtm_pkg::ST_IDLE;
      bound_r     <= dtm_pkg::BOUND_RESET;
      used_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bound_r     <= bound_nxt;
      used_r      <= used_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    last_r      <= last_nxt;
    taken_r     <= taken_nxt;
    prod_r      <= prod_nxt;
    div_r       <= div_nxt;
    rem_r       <= rem_nxt;
    root_r      <= root_nxt;
    flag_r      <= flag_nxt;
    cnt_r       <= cnt_nxt;
    out_value_r <= out_value_nxt;
    out_flag_r  <= out_flag_nxt;
  end

`include "assert_macros.svh"

  `DTM_ASSERT_IMPL(a_div_rem_below_bound, clk, rst_n, state_r == dtm_pkg::ST_DIV, rem_r < {1'b0, bound_r}, "divide remainder not below bound")
  `DTM_ASSERT_NEXT(a_sqrt_to_done, clk, rst_n, state_r == dtm_pkg::ST_SQRT && cnt_r == '0, state_r == dtm_pkg::ST_DONE, "root did not finish")
  `DTM_ASSERT_IMPL(a_result_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r) == dtm_pkg::ST_DONE, "result transfer not from done")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// testbench of distance_to_measure_unit: weight loads and neighbour streams
// are driven through the valid/stall input channel and the bound register is
// written through the cfg port between phases. A predictor keeps its own
// weight store and running sums and queues the expected distance to measure
// of each grid point; every result transfer is checked field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_LEN       = 300;
  localparam int SETTLE_CYCLES  = 80;
  localparam int PRINT_LIMIT    = 50;

  typedef struct packed {
    logic [dtm_pkg::VAL_W-1:0] dtm_value;
    logic                      bound_not_reached;
  } dtm_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_op = dtm_pkg::OP_LOAD;
  logic [dtm_pkg::IDX_W-1:0] in_sample_index = '0;
  logic [dtm_pkg::VAL_W-1:0] in_value = '0;
  logic                      in_last_neighbour = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [dtm_pkg::VAL_W-1:0] out_dtm_value;
  logic                      out_bound_not_reached;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [dtm_pkg::VAL_W-1:0] cfg_data = '0;

  // predictor state
  logic [dtm_pkg::VAL_W-1:0] weight_mem [dtm_pkg::SAMPLES];
  bit                        is_loaded [dtm_pkg::SAMPLES];
  int unsigned               loaded_idx [$];
  logic [dtm_pkg::VAL_W-1:0] bound_q = dtm_pkg::BOUND_RESET;
  logic [dtm_pkg::VAL_W-1:0] used_q = '0;
  logic [dtm_pkg::SUM_W-1:0] sum_q = '0;
  dtm_result_t               pending_dtm_q [$];

  int  errors = 0;
  int  items_sent = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;
  int  hold_requests = 0;
  int  hold_seen = 0;
  int  hold_cnt = 0;

  distance_to_measure_unit u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_op                 (in_op),
    .in_sample_index       (in_sample_index),
    .in_value              (in_value),
    .in_last_neighbour     (in_last_neighbour),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_dtm_value         (out_dtm_value),
    .out_bound_not_reached (out_bound_not_reached),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_data              (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [dtm_pkg::VAL_W-1:0] floor_sqrt(logic [31:0] x);
    logic [dtm_pkg::VAL_W-1:0] r;
    logic [dtm_pkg::VAL_W-1:0] t;
    r = '0;
    for (int b = dtm_pkg::VAL_W - 1; b >= 0; b--) begin
      t = r | (dtm_pkg::VAL_W'(1) << b);
      if (64'(t) * 64'(t) <= 64'(x)) r = t;
    end
    return r;
  endfunction

  function automatic void predict_item(logic op, logic [dtm_pkg::IDX_W-1:0] idx,
                                       logic [dtm_pkg::VAL_W-1:0] val, logic last);
    logic [dtm_pkg::VAL_W-1:0] w;
    logic [dtm_pkg::VAL_W-1:0] remaining;
    logic [dtm_pkg::VAL_W-1:0] taken;
    logic [63:0]               quo;
    logic [31:0]               q;
    dtm_result_t               res;
    if (op == dtm_pkg::OP_LOAD) begin
      weight_mem[idx] = val;
      if (!is_loaded[idx]) begin
        is_loaded[idx] = 1'b1;
        loaded_idx = {loaded_idx, 32'(idx)};
      end
    end else begin
      w = weight_mem[idx];
      remaining = (bound_q > used_q) ? bound_q - used_q : '0;
      taken = (w < remaining) ? w : remaining;
      used_q = used_q + taken;
      sum_q = sum_q + dtm_pkg::SUM_W'(64'(val) * 64'(val) * 64'(taken));
      if (last) begin
        if (bound_q == '0) begin
          res = '0;
        end else begin
          quo = 64'(sum_q) / 64'(bound_q);
          q = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
          res.dtm_value = floor_sqrt(q);
          res.bound_not_reached = (used_q < bound_q);
        end
        pending_dtm_q = {pending_dtm_q, res};
        used_q = '0;
        sum_q = '0;
      end
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (errors < PRINT_LIMIT) begin
      $display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    errors++;
  endtask

  // input transfer; valid stays high afterwards so back-to-back items need no drop
  task automatic send_item(logic op, logic [dtm_pkg::IDX_W-1:0] idx,
                           logic [dtm_pkg::VAL_W-1:0] val, logic last);
    while (!no_idle && $urandom_range(99) < 25) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_op = op;
    in_sample_index = idx;
    in_value = val;
    in_last_neighbour = last;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(op, idx, val, last);
    items_sent++;
    @(negedge clk);
  endtask

  // wait for all pending results, then let the datapath run empty
  task automatic settle();
    in_valid = 1'b0;
    while (pending_dtm_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_bound(logic [dtm_pkg::VAL_W-1:0] b);
    settle();
    cfg_data = b;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    bound_q = b;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [dtm_pkg::IDX_W-1:0] pick_loaded();
    return dtm_pkg::IDX_W'(loaded_idx[$urandom_range(loaded_idx.size() - 1)]);
  endfunction

  function automatic logic [dtm_pkg::VAL_W-1:0] random_weight();
    case ($urandom_range(3))
      0: return dtm_pkg::VAL_W'($urandom);
      1: return dtm_pkg::VAL_W'($urandom_range(0, 255));
      2: return dtm_pkg::VAL_W'($urandom_range(0, 1024));
      default: return dtm_pkg::VAL_W'($urandom_range(0, 16'h4000));
    endcase
  endfunction

  // grid points of well-ordered neighbours, with stray loads and unordered points
  task automatic run_traffic(int n_items);
    int                        target;
    int                        n;
    bit                        shuffled;
    logic [dtm_pkg::VAL_W-1:0] d;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(99) < 12) begin
        send_item(dtm_pkg::OP_LOAD,
                  dtm_pkg::IDX_W'($urandom_range(dtm_pkg::SAMPLES - 1)),
                  random_weight(), 1'($urandom_range(1)));
      end else begin
        n = $urandom_range(1, 8);
        shuffled = ($urandom_range(99) < 10);
        d = ($urandom_range(99) < 20) ? dtm_pkg::VAL_W'($urandom) :
                                        dtm_pkg::VAL_W'($urandom_range(0, 2047));
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(99) < 4) begin
            send_item(dtm_pkg::OP_LOAD,
                      dtm_pkg::IDX_W'($urandom_range(dtm_pkg::SAMPLES - 1)),
                      random_weight(), 1'b0);
          end
          send_item(dtm_pkg::OP_NEIGHBOR, pick_loaded(), d, k == n - 1);
          if (shuffled) d = dtm_pkg::VAL_W'($urandom);
          else d = (d > 16'hFFFF - 300) ? 16'hFFFF :
                   d + dtm_pkg::VAL_W'($urandom_range(0, 300));
        end
      end
    end
  endtask

  task automatic test_loads_and_edges();
    send_item(dtm_pkg::OP_LOAD, 10'd0, 16'h0100, 1'b0);
    send_item(dtm_pkg::OP_LOAD, 10'h3FF, 16'hFFFF, 1'b0);
    send_item(dtm_pkg::OP_LOAD, 10'h2AA, 16'h0080, 1'b0);
    send_item(dtm_pkg::OP_LOAD, 10'h155, 16'h0000, 1'b1);
    // zero weight, half budget, then budget spent
    send_item(dtm_pkg::OP_NEIGHBOR, 10'h155, 16'hFFFF, 1'b0);
    send_item(dtm_pkg::OP_NEIGHBOR, 10'h2AA, 16'h0100, 1'b0);
    send_item(dtm_pkg::OP_NEIGHBOR, 10'd0, 16'h0200, 1'b1);
    // neighbours run out before the bound, then points that reach it
    send_item(dtm_pkg::OP_NEIGHBOR, 10'h2AA, 16'h0001, 1'b1);
    send_item(dtm_pkg::OP_NEIGHBOR, 10'h3FF, 16'hFFFF, 1'b0);
    send_item(dtm_pkg::OP_NEIGHBOR, 10'd0, 16'hFFFF, 1'b1);
    send_item(dtm_pkg::OP_NEIGHBOR, 10'h3FF, 16'h0000, 1'b1);
  endtask

  task automatic test_bound_extremes();
    write_bound(16'hFFFF);
    send_item(dtm_pkg::OP_NEIGHBOR, 10'h3FF, 16'hFFFF, 1'b1);
    write_bound(16'd1);
    send_item(dtm_pkg::OP_NEIGHBOR, 10'h2AA, 16'h1234, 1'b1);
  endtask

  task automatic test_bound_zero();
    write_bound(16'd0);
    send_item(dtm_pkg::OP_NEIGHBOR, 10'd0, 16'h0100, 1'b1);
  endtask

  // bound lowered in the middle of a grid point, result saturates
  task automatic test_bound_lowered();
    write_bound(16'hFFFF);
    send_item(dtm_pkg::OP_NEIGHBOR, 10'h3FF, 16'hFFFF, 1'b0);
    send_item(dtm_pkg::OP_NEIGHBOR, 10'd0, 16'hF000, 1'b0);
    write_bound(16'd1);
    send_item(dtm_pkg::OP_NEIGHBOR, 10'h2AA, 16'hFFFF, 1'b1);
    write_bound(dtm_pkg::BOUND_RESET);
  endtask

  task automatic test_backpressure();
    hold_requests++;
    for (int i = 0; i < 12; i++) begin
      send_item(dtm_pkg::OP_NEIGHBOR, pick_loaded(), dtm_pkg::VAL_W'($urandom), 1'b1);
    end
    settle();
  endtask

  task automatic test_random_bounds();
    logic [dtm_pkg::VAL_W-1:0] bounds [5];
    bounds = '{16'd256, 16'd1, 16'hFFFF, dtm_pkg::VAL_W'($urandom_range(1, 65535)),
               dtm_pkg::VAL_W'($urandom_range(2, 1024))};
    foreach (bounds[i]) begin
      write_bound(bounds[i]);
      run_traffic(180);
    end
  endtask

  task automatic test_no_idle();
    write_bound(dtm_pkg::BOUND_RESET);
    no_idle = 1'b1;
    run_traffic(150);
    settle();
    no_idle = 1'b0;
  endtask

  // result side stall, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_cnt = HOLD_LEN;
    end
    if (hold_cnt > 0) begin
      out_stall = 1'b1;
      hold_cnt--;
    end else begin
      out_stall = !no_idle && ($urandom_range(99) < 25);
    end
  end

  always @(posedge clk) begin
    dtm_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dtm_q.size() == 0) begin
        report_mismatch("result with nothing pending", out_dtm_value, 0);
      end else begin
        want = pending_dtm_q.pop_front();
        if (out_dtm_value !== want.dtm_value) begin
          report_mismatch("dtm_value", out_dtm_value, want.dtm_value);
        end
        if (out_bound_not_reached !== want.bound_not_reached) begin
          report_mismatch("bound_not_reached", out_bound_not_reached, want.bound_not_reached);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_loads_and_edges();
    test_bound_extremes();
    test_bound_zero();
    test_bound_lowered();
    test_backpressure();
    test_random_bounds();
    test_no_idle();
    settle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dtm_pkg.sv
hw/rtl/dtm_csub.sv
hw/rtl/distance_to_measure_unit.sv
dv/tb.sv
